// ----- rtl/vpa_pkg.sv -----
// Shared types, constants and helpers for the vector primitive assembler.
// No dependencies; every rtl module imports this package.
package vpa_pkg;

  // Event codes carried in the action field
  localparam logic [3:0] ACT_BEGIN_LINES = 4'd0;
  localparam logic [3:0] ACT_LINE_VTX    = 4'd1;
  localparam logic [3:0] ACT_STRIP_RESET = 4'd2;
  localparam logic [3:0] ACT_STRIP_VTX   = 4'd3;
  localparam logic [3:0] ACT_BEGIN_LOOP  = 4'd4;
  localparam logic [3:0] ACT_LOOP_VTX    = 4'd5;
  localparam logic [3:0] ACT_END_LOOP    = 4'd6;
  localparam logic [3:0] ACT_POINT       = 4'd7;
  localparam logic [3:0] ACT_LINE        = 4'd8;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_TOP    = 2'd2;

  localparam logic [15:0] SCALE_RESET    = 16'd3518;
  localparam logic [15:0] OFFSET_X_RESET = 16'd8025;
  localparam logic [15:0] Y_TOP_RESET    = 16'd4320;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned IN_W  = 104;
  localparam int unsigned OUT_W = 80;

  typedef struct packed {
    logic [15:0] scale_q8;
    logic [15:0] offset_x_q4;
    logic [15:0] y_top_q4;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [31:0] xy;       // pos_y in 31:16, pos_x in 15:0
    logic [31:0] end_xy;
    logic [31:0] colour;   // alpha, blue, green, red from the top down
  } item_t;

  typedef struct packed {
    logic [31:0] from_xy;
    logic [31:0] to_xy;
    logic [31:0] colour;
    logic        point;
  } seg_t;

  // Drop negatives, take the integer part of a Q12 value, saturate at 4095
  function automatic logic [11:0] clamp_q12(input logic signed [34:0] v);
    logic [11:0] r;
    if (v[34])
      r = 12'd0;
    else if (|v[33:24])
      r = 12'd4095;
    else
      r = v[23:12];
    return r;
  endfunction

  // floor(p / 255), exact for any product of two 8-bit values
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] t;
    t = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

// ----- rtl/vector_primitive_assembler.sv -----
// Top level of the vector primitive assembler: configuration registers,
// front end, segment queue and back end. Depends on vpa_pkg and all vpa_* modules.
//
//  channel  dir  handshake              payload
//  s_*      in   s_tvalid / s_tready    s_tdata  : vertex event item
//  m_*      out  m_tvalid / m_tready    m_tdata  : display segment item
//  cfg_*    in   cfg_valid / cfg_ready  cfg_index, cfg_data : register write
//
// One item per clock sustained while m_tready stays high. A segment reaches
// m_tdata through the queue, the multiply stage and the output register.
// The queue of QUEUE_DEPTH entries lets the front keep taking events while
// the output stalls; s_tready drops only when the queue is full.
// Reset clears the vertex valid bits, the queue and the output, and loads
// the register defaults. cfg_ready is always high.
module vector_primitive_assembler
  import vpa_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // action[3:0] pos_x[19:4] pos_y[35:20] end_x[51:36] end_y[67:52]
  // red_in[75:68] green_in[83:76] blue_in[91:84] alpha_in[99:92], zero pad
  input  logic [IN_W-1:0]      s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // start_x[11:0] start_y[23:12] stop_x[36:24] stop_y[48:37]
  // red_out[56:49] green_out[64:57] blue_out[72:65], zero pad
  output logic [OUT_W-1:0]     m_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cfg_t  cfg;
  item_t item;
  seg_t  push_seg;
  seg_t  q_seg;
  logic  push;
  logic  q_full;
  logic  q_valid;
  logic  q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_q8    <= SCALE_RESET;
      cfg.offset_x_q4 <= OFFSET_X_RESET;
      cfg.y_top_q4    <= Y_TOP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCALE:    cfg.scale_q8    <= cfg_data;
        REG_OFFSET_X: cfg.offset_x_q4 <= cfg_data;
        REG_Y_TOP:    cfg.y_top_q4    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign item.action = s_tdata[3:0];
  assign item.xy     = {s_tdata[35:20], s_tdata[19:4]};
  assign item.end_xy = {s_tdata[67:52], s_tdata[51:36]};
  assign item.colour = s_tdata[99:68];

  vpa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (item),
    .q_full   (q_full),
    .push     (push),
    .seg      (push_seg)
  );

  vpa_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_seg  (push_seg),
    .full      (q_full),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_seg   (q_seg)
  );

  vpa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .seg_valid (q_valid),
    .seg_ready (q_ready),
    .seg       (q_seg),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

`ifndef NO_ASSERTIONS
  a_line_queued: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tdata[3:0] == ACT_LINE) |=> q_valid)
    else $error("line event did not reach the queue");

  a_queue_keeps: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !q_ready) |=> q_valid)
    else $error("queued segment lost while back end stalled");

  a_stop_x_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[36:24] <= 13'd4096))
    else $error("stop_x beyond 4096");
`endif

endmodule

// ----- rtl/vpa_front.sv -----
// Front end: accepts vertex events, tracks pair/strip/loop state and
// issues segment commands to the queue. Depends on vpa_pkg.
module vpa_front
  import vpa_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  q_full,
  output logic  push,
  output seg_t  seg
);

  logic        pair_pending;
  logic [31:0] pair_first_xy;
  logic        strip_has_prev;
  logic [31:0] strip_prev_xy;
  logic        loop_has_first;
  logic        loop_has_prev;
  logic [31:0] loop_first_xy;
  logic [31:0] loop_first_colour;
  logic [31:0] loop_prev_xy;

  logic accept;
  logic emit;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit;

  always_comb begin
    emit         = 1'b0;
    seg.from_xy  = in_item.xy;
    seg.to_xy    = in_item.end_xy;
    seg.colour   = in_item.colour;
    seg.point    = 1'b0;
    case (in_item.action)
      ACT_LINE_VTX: begin
        emit         = pair_pending;
        seg.from_xy  = pair_first_xy;
        seg.to_xy    = in_item.xy;
      end
      ACT_STRIP_VTX: begin
        emit         = strip_has_prev;
        seg.from_xy  = strip_prev_xy;
        seg.to_xy    = in_item.xy;
      end
      ACT_LOOP_VTX: begin
        emit         = loop_has_prev;
        seg.from_xy  = loop_prev_xy;
        seg.to_xy    = in_item.xy;
      end
      ACT_END_LOOP: begin
        emit         = loop_has_prev && loop_has_first;
        seg.from_xy  = loop_prev_xy;
        seg.to_xy    = loop_first_xy;
        seg.colour   = loop_first_colour;
      end
      ACT_POINT: begin
        emit         = 1'b1;
        seg.to_xy    = in_item.xy;
        seg.point    = 1'b1;
      end
      ACT_LINE: begin
        emit         = 1'b1;
      end
      default: begin
        emit         = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_pending   <= 1'b0;
      strip_has_prev <= 1'b0;
      loop_has_first <= 1'b0;
      loop_has_prev  <= 1'b0;
    end else if (accept) begin
      case (in_item.action)
        ACT_BEGIN_LINES: pair_pending <= 1'b0;
        ACT_LINE_VTX: begin
          if (!pair_pending)
            pair_first_xy <= in_item.xy;
          pair_pending <= !pair_pending;
        end
        ACT_STRIP_RESET: strip_has_prev <= 1'b0;
        ACT_STRIP_VTX: begin
          strip_prev_xy  <= in_item.xy;
          strip_has_prev <= 1'b1;
        end
        ACT_BEGIN_LOOP, ACT_END_LOOP: begin
          loop_has_first <= 1'b0;
          loop_has_prev  <= 1'b0;
        end
        ACT_LOOP_VTX: begin
          if (!loop_has_first) begin
            loop_first_xy     <= in_item.xy;
            loop_first_colour <= in_item.colour;
          end
          loop_has_first <= 1'b1;
          loop_prev_xy   <= in_item.xy;
          loop_has_prev  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/vpa_queue.sv -----
// Short segment queue between front and back ends.
// Depends on vpa_pkg for the segment type.
module vpa_queue
  import vpa_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  seg_t push_seg,
  output logic full,
  output logic out_valid,
  input  logic out_ready,
  output seg_t out_seg
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  seg_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_seg   = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push)
      mem[wr_ptr] <= push_seg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)
        count <= count + 1'b1;
      else if (pop && !push)
        count <= count - 1'b1;
    end
  end

endmodule

// ----- rtl/vpa_back.sv -----
// Back end: maps segment endpoints to display coordinates and weighs the
// colour by alpha in two registered stages. Depends on vpa_pkg.
module vpa_back
  import vpa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             seg_valid,
  output logic             seg_ready,
  input  seg_t             seg,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata
);

  logic en;

  logic signed [16:0] scale_s;
  logic signed [16:0] y_top_s;
  logic signed [16:0] dy_from;
  logic signed [16:0] dy_to;
  logic signed [32:0] mul_sx;
  logic signed [32:0] mul_ex;
  logic signed [33:0] mul_sy;
  logic signed [33:0] mul_ey;

  logic               s1_valid;
  logic               s1_point;
  logic signed [32:0] s1_sx;
  logic signed [32:0] s1_ex;
  logic signed [33:0] s1_sy;
  logic signed [33:0] s1_ey;
  logic [15:0]        s1_r;
  logic [15:0]        s1_g;
  logic [15:0]        s1_b;

  logic signed [34:0] off_s;
  logic [11:0]        sx;
  logic [11:0]        sy;
  logic [11:0]        ex;
  logic [11:0]        ey;
  logic [12:0]        stop_x;
  logic [11:0]        stop_y;

  assign en        = !m_tvalid || m_tready;
  assign seg_ready = en;

  // stage 1: one multiply per coordinate
  assign scale_s = {1'b0, cfg.scale_q8};
  assign y_top_s = {cfg.y_top_q4[15], cfg.y_top_q4};
  assign dy_from = y_top_s - {seg.from_xy[31], seg.from_xy[31:16]};
  assign dy_to   = y_top_s - {seg.to_xy[31], seg.to_xy[31:16]};
  assign mul_sx  = $signed(seg.from_xy[15:0]) * scale_s;
  assign mul_ex  = $signed(seg.to_xy[15:0]) * scale_s;
  assign mul_sy  = dy_from * scale_s;
  assign mul_ey  = dy_to * scale_s;

  always_ff @(posedge clk) begin
    if (rst)
      s1_valid <= 1'b0;
    else if (en)
      s1_valid <= seg_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_point <= seg.point;
      s1_sx    <= mul_sx;
      s1_ex    <= mul_ex;
      s1_sy    <= mul_sy;
      s1_ey    <= mul_ey;
      s1_r     <= seg.colour[7:0] * seg.colour[31:24];
      s1_g     <= seg.colour[15:8] * seg.colour[31:24];
      s1_b     <= seg.colour[23:16] * seg.colour[31:24];
    end
  end

  // stage 2: offset, clamp, colour divide
  assign off_s  = {11'd0, cfg.offset_x_q4, 8'd0};
  assign sx     = clamp_q12({{2{s1_sx[32]}}, s1_sx} + off_s);
  assign ex     = clamp_q12({{2{s1_ex[32]}}, s1_ex} + off_s);
  assign sy     = clamp_q12({s1_sy[33], s1_sy});
  assign ey     = clamp_q12({s1_ey[33], s1_ey});
  // a point is one display unit wide and may reach 4096
  assign stop_x = s1_point ? ({1'b0, sx} + 13'd1) : {1'b0, ex};
  assign stop_y = s1_point ? sy : ey;

  always_ff @(posedge clk) begin
    if (rst)
      m_tvalid <= 1'b0;
    else if (en)
      m_tvalid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (en)
      m_tdata <= {7'd0, div255(s1_b), div255(s1_g), div255(s1_r),
                  stop_y, stop_x, sy, sx};
  end

endmodule

// ----- bench/tb_vector_primitive_assembler.sv -----
// Self-checking bench for vector_primitive_assembler: vertex events in, display segments out.
// Segment predictor, stream driver and monitor with random stalls on both sides.
// Depends on vpa_pkg and the rtl top level.
module tb_vector_primitive_assembler;
  import vpa_pkg::*;

  // action codes the block ignores
  localparam logic [3:0] ACT_UNUSED_LO = 4'd9;
  localparam logic [3:0] ACT_UNUSED_HI = 4'd15;
  localparam int unsigned ITEMS_PER_PHASE = 144;
  localparam int unsigned PHASES = 8;

  typedef struct {
    logic [3:0]         action;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } vertex_event_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } spot_t;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } tint_t;

  typedef struct {
    logic [11:0] start_x;
    logic [11:0] start_y;
    logic [12:0] stop_x;
    logic [11:0] stop_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } segment_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  vector_primitive_assembler dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  vertex_event_t pending_events[$];
  segment_t      segments_due[$];
  vertex_event_t in_item;
  bit            in_busy = 1'b0;
  int            in_wait = 0;
  int            out_wait = 0;
  int            in_gap_max = 10;
  int            out_gap_max = 10;
  int            stim_count = 0;
  int            mismatches = 0;

  // predictor copy of registers and vertex state
  logic [15:0]        scale_now = SCALE_RESET;
  logic [15:0]        offset_now = OFFSET_X_RESET;
  logic signed [15:0] ytop_now = Y_TOP_RESET;
  bit                 pair_open = 1'b0;
  spot_t              pair_head;
  bit                 strip_live = 1'b0;
  spot_t              strip_tail;
  bit                 loop_started = 1'b0;
  bit                 loop_live = 1'b0;
  spot_t              loop_head;
  tint_t              loop_head_tint;
  spot_t              loop_tail;

  task automatic flag_mismatch(string field, int got, int want);
    $display("%0t segment %s: got %0d, expected %0d", $time, field, got, want);
    mismatches++;
  endtask

  function automatic logic [11:0] saturate_q12(longint v);
    longint q;
    if (v < 0) return 12'd0;
    q = v / 4096;
    return (q > 4095) ? 12'd4095 : q[11:0];
  endfunction

  function automatic logic [11:0] disp_x(spot_t s);
    return saturate_q12(longint'(s.x) * longint'(scale_now) + longint'(offset_now) * 256);
  endfunction

  function automatic logic [11:0] disp_y(spot_t s);
    return saturate_q12((longint'(ytop_now) - longint'(s.y)) * longint'(scale_now));
  endfunction

  function automatic logic [7:0] weigh(logic [7:0] c, logic [7:0] a);
    int p;
    p = int'(c) * int'(a);
    return 8'(p / 255);
  endfunction

  function automatic segment_t make_segment(spot_t from, spot_t to, tint_t t, bit point);
    segment_t s;
    s.start_x = disp_x(from);
    s.start_y = disp_y(from);
    s.stop_x  = point ? {1'b0, s.start_x} + 13'd1 : {1'b0, disp_x(to)};
    s.stop_y  = point ? s.start_y : disp_y(to);
    s.red     = weigh(t.r, t.a);
    s.green   = weigh(t.g, t.a);
    s.blue    = weigh(t.b, t.a);
    return s;
  endfunction

  // advance vertex state for one accepted item, queue the segment it yields
  function automatic void assemble(vertex_event_t ev);
    spot_t at;
    spot_t far;
    tint_t tint;
    at.x = ev.pos_x;
    at.y = ev.pos_y;
    far.x = ev.end_x;
    far.y = ev.end_y;
    tint.r = ev.red;
    tint.g = ev.green;
    tint.b = ev.blue;
    tint.a = ev.alpha;
    case (ev.action)
      ACT_BEGIN_LINES: pair_open = 1'b0;
      ACT_LINE_VTX: begin
        if (!pair_open) begin
          pair_head = at;
          pair_open = 1'b1;
        end else begin
          segments_due.push_back(make_segment(pair_head, at, tint, 1'b0));
          pair_open = 1'b0;
        end
      end
      ACT_STRIP_RESET: strip_live = 1'b0;
      ACT_STRIP_VTX: begin
        if (strip_live)
          segments_due.push_back(make_segment(strip_tail, at, tint, 1'b0));
        strip_tail = at;
        strip_live = 1'b1;
      end
      ACT_BEGIN_LOOP: begin
        loop_started = 1'b0;
        loop_live = 1'b0;
      end
      ACT_LOOP_VTX: begin
        if (!loop_started) begin
          loop_head = at;
          loop_head_tint = tint;
          loop_started = 1'b1;
        end
        if (loop_live)
          segments_due.push_back(make_segment(loop_tail, at, tint, 1'b0));
        loop_tail = at;
        loop_live = 1'b1;
      end
      ACT_END_LOOP: begin
        // closing edge uses the first vertex's colour
        if (loop_live && loop_started)
          segments_due.push_back(make_segment(loop_tail, loop_head, loop_head_tint, 1'b0));
        loop_started = 1'b0;
        loop_live = 1'b0;
      end
      ACT_POINT: segments_due.push_back(make_segment(at, at, tint, 1'b1));
      ACT_LINE: segments_due.push_back(make_segment(at, far, tint, 1'b0));
      default: ;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4: return 16'($urandom);
      default: return 16'(int'($urandom_range(0, 4800)) - 500);
    endcase
  endfunction

  function automatic vertex_event_t make_event(logic [3:0] act);
    vertex_event_t ev;
    ev.action = act;
    ev.pos_x = pick_coord();
    ev.pos_y = pick_coord();
    ev.end_x = pick_coord();
    ev.end_y = pick_coord();
    ev.red = 8'($urandom);
    ev.green = 8'($urandom);
    ev.blue = 8'($urandom);
    ev.alpha = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
    return ev;
  endfunction

  function automatic void queue_event(vertex_event_t ev);
    pending_events.push_back(ev);
    if (ev.action <= ACT_LINE) stim_count++;
  endfunction

  function automatic void add_directed();
    vertex_event_t ev;
    ev = make_event(ACT_POINT);
    ev.pos_x = 16'h7FFF; ev.pos_y = 16'h8000;
    ev.red = 8'hFF; ev.green = 8'hFF; ev.blue = 8'hFF; ev.alpha = 8'hFF;
    queue_event(ev);
    ev = make_event(ACT_POINT);
    ev.pos_x = 16'h8000; ev.pos_y = 16'h7FFF;
    ev.red = 8'h00; ev.green = 8'h00; ev.blue = 8'h00; ev.alpha = 8'h00;
    queue_event(ev);
    // point right at the edge: stop_x runs one past the screen
    ev = make_event(ACT_POINT);
    ev.pos_x = 16'd4200; ev.pos_y = 16'd100;
    queue_event(ev);
    ev = make_event(ACT_LINE);
    ev.pos_x = 16'h8000; ev.pos_y = 16'h7FFF; ev.end_x = 16'h7FFF; ev.end_y = 16'h8000;
    ev.red = 8'hFF; ev.green = 8'h80; ev.blue = 8'h01; ev.alpha = 8'h80;
    queue_event(ev);
    ev = make_event(ACT_LINE);
    ev.pos_x = 16'd100; ev.pos_y = 16'd200; ev.end_x = 16'd3000; ev.end_y = 16'd4000;
    queue_event(ev);
    queue_event(make_event(ACT_UNUSED_LO));
    queue_event(make_event(ACT_UNUSED_HI));
    // lone line vertex dropped by begin, then a full pair
    queue_event(make_event(ACT_BEGIN_LINES));
    queue_event(make_event(ACT_LINE_VTX));
    queue_event(make_event(ACT_BEGIN_LINES));
    queue_event(make_event(ACT_LINE_VTX));
    queue_event(make_event(ACT_LINE_VTX));
    queue_event(make_event(ACT_STRIP_RESET));
    repeat (3) queue_event(make_event(ACT_STRIP_VTX));
    queue_event(make_event(ACT_STRIP_RESET));
    queue_event(make_event(ACT_STRIP_VTX));
    queue_event(make_event(ACT_BEGIN_LOOP));
    repeat (3) queue_event(make_event(ACT_LOOP_VTX));
    queue_event(make_event(ACT_END_LOOP));
    // loop closed with one vertex, then with none
    queue_event(make_event(ACT_BEGIN_LOOP));
    queue_event(make_event(ACT_LOOP_VTX));
    queue_event(make_event(ACT_END_LOOP));
    queue_event(make_event(ACT_END_LOOP));
  endfunction

  function automatic void add_random_sequence();
    int n;
    case ($urandom_range(0, 9))
      0, 1: begin
        queue_event(make_event(ACT_BEGIN_LINES));
        n = $urandom_range(1, 6);
        repeat (n) queue_event(make_event(ACT_LINE_VTX));
      end
      2, 3: begin
        queue_event(make_event(ACT_STRIP_RESET));
        n = $urandom_range(1, 8);
        repeat (n) queue_event(make_event(ACT_STRIP_VTX));
      end
      4, 5: begin
        queue_event(make_event(ACT_BEGIN_LOOP));
        n = $urandom_range(0, 6);
        repeat (n) queue_event(make_event(ACT_LOOP_VTX));
        if ($urandom_range(0, 4) != 0) queue_event(make_event(ACT_END_LOOP));
      end
      6: queue_event(make_event(ACT_POINT));
      7: queue_event(make_event(ACT_LINE));
      8: begin
        n = $urandom_range(1, 3);
        repeat (n) queue_event(make_event(4'($urandom_range(0, 15))));
      end
      default: begin
        n = $urandom_range(1, 4);
        repeat (n) queue_event(make_event(4'($urandom_range(ACT_BEGIN_LINES, ACT_LINE))));
      end
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SCALE:    scale_now = val;
      REG_OFFSET_X: offset_now = val;
      REG_Y_TOP:    ytop_now = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(logic [15:0] scale, logic [15:0] offset, logic [15:0] ytop);
    write_reg(REG_SCALE, scale);
    write_reg(REG_OFFSET_X, offset);
    write_reg(REG_Y_TOP, ytop);
  endtask

  // sender holds off until every segment is back, then waits on so that stray segments can still show
  task automatic wait_idle();
    while (pending_events.size() != 0 || in_busy || segments_due.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // sender: a random gap before each item, hold until taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!in_busy) begin
      if (in_wait > 0) begin
        in_wait--;
        s_tvalid <= 1'b0;
      end else if (pending_events.size() > 0) begin
        in_item = pending_events.pop_front();
        s_tdata <= {4'd0, in_item.alpha, in_item.blue, in_item.green, in_item.red,
                    in_item.end_y, in_item.end_x, in_item.pos_y, in_item.pos_x,
                    in_item.action};
        s_tvalid <= 1'b1;
        in_busy = 1'b1;
        in_wait = $urandom_range(0, in_gap_max);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stall after each segment
  always @(negedge clk) begin
    if (out_wait > 0) begin
      out_wait--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    segment_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        assemble(in_item);
        in_busy = 1'b0;
      end
      if (m_tvalid && m_tready) begin
        if (segments_due.size() == 0) begin
          flag_mismatch("with none expected, start_x", m_tdata[11:0], 0);
        end else begin
          want = segments_due.pop_front();
          if (m_tdata[11:0] !== want.start_x)
            flag_mismatch("start_x", m_tdata[11:0], want.start_x);
          if (m_tdata[23:12] !== want.start_y)
            flag_mismatch("start_y", m_tdata[23:12], want.start_y);
          if (m_tdata[36:24] !== want.stop_x)
            flag_mismatch("stop_x", m_tdata[36:24], want.stop_x);
          if (m_tdata[48:37] !== want.stop_y)
            flag_mismatch("stop_y", m_tdata[48:37], want.stop_y);
          if (m_tdata[56:49] !== want.red)
            flag_mismatch("red_out", m_tdata[56:49], want.red);
          if (m_tdata[64:57] !== want.green)
            flag_mismatch("green_out", m_tdata[64:57], want.green);
          if (m_tdata[72:65] !== want.blue)
            flag_mismatch("blue_out", m_tdata[72:65], want.blue);
        end
        out_wait = $urandom_range(0, out_gap_max);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        case (p)
          1: apply_settings(16'd1, 16'd0, 16'h8000);
          2: apply_settings(16'hFFFF, 16'hFFFF, 16'h7FFF);
          4: apply_settings(SCALE_RESET, OFFSET_X_RESET, Y_TOP_RESET);
          6: apply_settings(16'd256, 16'h8000, 16'd0);
          default: apply_settings(16'($urandom_range(1, 8191)), 16'($urandom_range(0, 16383)),
                                  16'(int'($urandom_range(0, 8191)) - 2048));
        endcase
      end
      in_gap_max = (p % 3 == 1 || p == 5) ? 0 : 10;
      out_gap_max = (p % 4 == 2 || p == 5) ? 0 : 10;
      if (p == 0) add_directed();
      while (stim_count < (p + 1) * ITEMS_PER_PHASE) add_random_sequence();
    end
    wait_idle();
    if (mismatches == 0 && segments_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
